### rtl/vlpd_pkg.sv
// ----------------------------------------------------------------------------
// vlpd_pkg
// Shared widths, codes and types for the length-prefixed varint decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vlpd_pkg;

    localparam int unsigned BYTE_W            = 8;
    localparam int unsigned VALUE_W           = 64;
    localparam int unsigned CNT_W             = 4;
    localparam int unsigned MAX_PAYLOAD_BYTES = 8;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_IMMEDIATE_LIMIT = 3'd0;
    localparam logic [BYTE_W-1:0]     LIMIT_RESET          = 8'd240;

    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_BAD_LENGTH = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic               status;
    } result_t;

endpackage

`default_nettype wire

### rtl/vlpd_core.sv
// ----------------------------------------------------------------------------
// vlpd_core
// Header/payload parser: holds the payload state and forms one result per
// completed value or bad header.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlpd_core #(
    parameter int unsigned MAX_PAYLOAD_BYTES = vlpd_pkg::MAX_PAYLOAD_BYTES
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        accept,
    input  wire logic [vlpd_pkg::BYTE_W-1:0] in_byte,
    input  wire logic [vlpd_pkg::BYTE_W-1:0] immediate_limit,
    output vlpd_pkg::result_t                result
);

    localparam int unsigned BW = vlpd_pkg::BYTE_W;
    localparam int unsigned VW = vlpd_pkg::VALUE_W;
    localparam int unsigned CW = vlpd_pkg::CNT_W;

    logic          in_payload_reg, in_payload_next;
    logic [CW-1:0] bytes_left_reg, bytes_left_next;
    logic [VW-1:0] acc_reg, acc_next;
    logic [BW-1:0] len;

    assign len = in_byte - immediate_limit;

    always_comb begin
        in_payload_next = in_payload_reg;
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        result          = '0;
        if (accept) begin
            if (in_payload_reg) begin
                acc_next        = {acc_reg[VW-BW-1:0], in_byte};
                bytes_left_next = bytes_left_reg - CW'(1);
                if (bytes_left_next == '0) begin
                    in_payload_next = 1'b0;
                    result.valid    = 1'b1;
                    result.value    = acc_next;
                    result.status   = vlpd_pkg::STATUS_OK;
                end
            end else if (in_byte == immediate_limit) begin
                result.valid  = 1'b1;
                result.value  = '0;
                result.status = vlpd_pkg::STATUS_OK;
            end else if (in_byte < immediate_limit) begin
                result.valid  = 1'b1;
                result.value  = VW'(in_byte);
                result.status = vlpd_pkg::STATUS_OK;
            end else if (len > BW'(MAX_PAYLOAD_BYTES)) begin
                result.valid  = 1'b1;
                result.value  = '0;
                result.status = vlpd_pkg::STATUS_BAD_LENGTH;
            end else begin
                in_payload_next = 1'b1;
                bytes_left_next = len[CW-1:0];
                acc_next        = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg <= 1'b0;
            bytes_left_reg <= '0;
        end else begin
            in_payload_reg <= in_payload_next;
            bytes_left_reg <= bytes_left_next;
        end
        acc_reg <= acc_next;
    end

endmodule

`default_nettype wire

### rtl/vlpd_out_stage.sv
// ----------------------------------------------------------------------------
// vlpd_out_stage
// Result register of the decoder; loads while empty or while being drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlpd_out_stage (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire vlpd_pkg::result_t            result,
    output logic                              load_ok,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [vlpd_pkg::VALUE_W-1:0]      m_tdata,
    output logic                              m_tuser
);

    logic                         valid_reg, valid_next;
    logic [vlpd_pkg::VALUE_W-1:0] value_reg;
    logic                         status_reg;

    assign load_ok = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load_ok) begin
            valid_next = result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load_ok && result.valid) begin
            value_reg  <= result.value;
            status_reg <= result.status;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = status_reg;

endmodule

`default_nettype wire

### rtl/varint_length_prefixed_decoder_top.sv
// ----------------------------------------------------------------------------
// varint_length_prefixed_decoder_top
// Decodes length-prefixed big-endian varints from a byte stream.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while m_tready is high; input stalls while
// a result waits in the result register with m_tready low.
// A result is valid in the cycle after the byte that completes it; the single
// result register lies between the two and loads while being drained.
// Reset (aresetn low, synchronous): header state, output empty, limit 240.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module varint_length_prefixed_decoder_top #(
    parameter int unsigned MAX_PAYLOAD_BYTES = vlpd_pkg::MAX_PAYLOAD_BYTES
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // APB configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [vlpd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [vlpd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [vlpd_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    // input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,  // [7:0] in_byte
    // result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [63:0]                            m_tdata,  // [63:0] value
    output logic                                   m_tuser   // [0] status
);

    localparam int unsigned BW = vlpd_pkg::BYTE_W;
    localparam int unsigned DW = vlpd_pkg::APB_DATA_W;

    logic [BW-1:0]     limit_reg, limit_next;
    logic              cfg_write;
    vlpd_pkg::result_t result;
    logic              load_ok;
    logic              accept;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        limit_next = limit_reg;
        if (cfg_write && paddr == vlpd_pkg::ADDR_IMMEDIATE_LIMIT) begin
            limit_next = pwdata[BW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= vlpd_pkg::LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == vlpd_pkg::ADDR_IMMEDIATE_LIMIT) begin
            prdata = DW'(limit_reg);
        end
    end

    assign s_tready = load_ok;
    assign accept   = s_tvalid && s_tready;

    vlpd_core #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .in_byte        (s_tdata),
        .immediate_limit(limit_reg),
        .result         (result)
    );

    vlpd_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .result  (result),
        .load_ok (load_ok),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    a_err_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == vlpd_pkg::STATUS_BAD_LENGTH |-> m_tdata == '0)
        else $error("error result carries a nonzero value");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result register is full and stalled");

    a_limit_reset: assert property (@(posedge aclk)
        !aresetn |=> limit_reg == vlpd_pkg::LIMIT_RESET)
        else $error("immediate limit not restored by reset");

    a_result_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |-> accept)
        else $error("result formed without an accepted item");

endmodule

`default_nettype wire
